/* rtl/core/bsfp_pkg.sv */
// Shared types and constants for the byte-stuffing frame packer.
package bsfp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0] HEADER_MARK_RESET = 8'd170;
    localparam logic [BYTE_W-1:0] TAIL_MARK_RESET = 8'd85;
    localparam logic [BYTE_W-1:0] ESCAPE_MARK_RESET = 8'd165;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEADER_MARK = 2'd0,
        CFG_TAIL_MARK   = 2'd1,
        CFG_ESCAPE_MARK = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_mark;
        logic [BYTE_W-1:0] tail_mark;
        logic [BYTE_W-1:0] escape_mark;
    } marks_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              data_esc;
        logic              start;
        logic              last;
        logic [BYTE_W-1:0] sum;
        logic              sum_esc;
    } cmd_t;

    function automatic logic is_mark(input logic [BYTE_W-1:0] b, input marks_t m);
        return (b == m.header_mark) || (b == m.tail_mark) || (b == m.escape_mark);
    endfunction

endpackage

/* rtl/core/bsfp_front.sv */
// Front end: accepts body bytes, tracks frame state and the checksum, builds commands.
module bsfp_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  logic [7:0]      data_byte,
    input  logic            last_byte,
    input  bsfp_pkg::marks_t marks,
    input  logic            queue_full,
    output logic            cmd_wr_en,
    output bsfp_pkg::cmd_t  cmd
);

    logic                         in_frame_reg;
    logic                         in_frame_next;
    logic [bsfp_pkg::BYTE_W-1:0]  sum_reg;
    logic [bsfp_pkg::BYTE_W-1:0]  sum_next;
    logic [bsfp_pkg::BYTE_W-1:0]  new_sum;

    assign cmd_wr_en = push && !queue_full;

    always_comb
    begin
        new_sum = (in_frame_reg ? sum_reg : '0) + data_byte;
        cmd.data = data_byte;
        cmd.data_esc = bsfp_pkg::is_mark(data_byte, marks);
        cmd.start = !in_frame_reg;
        cmd.last = last_byte;
        cmd.sum = new_sum;
        cmd.sum_esc = bsfp_pkg::is_mark(new_sum, marks);
        in_frame_next = in_frame_reg;
        sum_next = sum_reg;
        if (cmd_wr_en)
        begin
            in_frame_next = !last_byte;
            sum_next = last_byte ? '0 : new_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            sum_reg <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            sum_reg <= sum_next;
        end
    end

endmodule

/* rtl/core/bsfp_queue.sv */
// Short command queue between the front end and the byte sequencer.
module bsfp_queue
#(
    parameter int unsigned DEPTH = bsfp_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  bsfp_pkg::cmd_t wr_cmd,
    output logic           full,
    output logic           head_valid,
    output bsfp_pkg::cmd_t head_cmd,
    input  logic           rd_en
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    bsfp_pkg::cmd_t     store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd = store_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/bsfp_back.sv */
// Back end: steps through the wire bytes of each command and holds the output beat.
module bsfp_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  bsfp_pkg::marks_t marks,
    input  logic             head_valid,
    input  bsfp_pkg::cmd_t   head_cmd,
    output logic             head_pop,
    output logic             beat_load,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       out_byte,
    output logic             last_out
);

    typedef enum logic [2:0] {
        PH_HDR1  = 3'd0,
        PH_HDR2  = 3'd1,
        PH_ESC_D = 3'd2,
        PH_DATA  = 3'd3,
        PH_ESC_S = 3'd4,
        PH_SUM   = 3'd5,
        PH_TAIL1 = 3'd6,
        PH_TAIL2 = 3'd7
    } phase_t;

    phase_t      phase_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        last_out_reg;

    logic [7:0]  applies;
    logic [7:0]  pending;
    logic [7:0]  remaining;
    phase_t      cur_phase;
    logic        cmd_done;
    logic [7:0]  beat_byte;

    always_comb
    begin
        applies = '0;
        applies[PH_HDR1] = head_cmd.start;
        applies[PH_HDR2] = head_cmd.start;
        applies[PH_ESC_D] = head_cmd.data_esc;
        applies[PH_DATA] = 1'b1;
        applies[PH_ESC_S] = head_cmd.last && head_cmd.sum_esc;
        applies[PH_SUM] = head_cmd.last;
        applies[PH_TAIL1] = head_cmd.last;
        applies[PH_TAIL2] = head_cmd.last;

        pending = applies & (8'hFF << phase_reg);
        cur_phase = PH_DATA;
        for (int i = 7; i >= 0; i--)
        begin
            if (pending[i])
            begin
                cur_phase = phase_t'(3'(i));
            end
        end
        remaining = applies & (8'hFE << cur_phase);
        cmd_done = (remaining == '0);

        unique case (cur_phase)
            PH_HDR1, PH_HDR2:    beat_byte = marks.header_mark;
            PH_ESC_D, PH_ESC_S:  beat_byte = marks.escape_mark;
            PH_DATA:             beat_byte = head_cmd.data;
            PH_SUM:              beat_byte = head_cmd.sum;
            PH_TAIL1, PH_TAIL2:  beat_byte = marks.tail_mark;
        endcase
    end

    assign beat_load = head_valid && (!out_valid_reg || pop);
    assign head_pop = beat_load && cmd_done;
    assign empty = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign last_out = last_out_reg;

    always_ff @(posedge clk)
    begin
        if (beat_load)
        begin
            out_byte_reg <= beat_byte;
            last_out_reg <= (cur_phase == PH_TAIL2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (beat_load)
            begin
                out_valid_reg <= 1'b1;
                phase_reg <= cmd_done ? PH_HDR1 : phase_t'(cur_phase + 3'd1);
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/core/byte_stuffing_frame_packer_top.sv */
// Byte-stuffing frame packer: mark registers, front end, command queue and byte sequencer.
// Path: an accepted body byte is registered in the command queue, then its wire bytes go
// through the output beat register. Throughput: one wire beat per cycle while the output
// is popped; a body byte causes one to eight wire bytes in the sequencer, and the front end
// accepts one byte per cycle while the command queue has room.
// Reset: queue, sequencer and frame state are cleared; marks return to 170, 85 and 165.
module byte_stuffing_frame_packer_top
#(
    parameter int unsigned QUEUE_DEPTH = bsfp_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last_out,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    bsfp_pkg::marks_t marks_reg;
    logic             cmd_wr_en;
    bsfp_pkg::cmd_t   cmd;
    logic             head_valid;
    bsfp_pkg::cmd_t   head_cmd;
    logic             head_pop;
    logic             beat_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg.header_mark <= bsfp_pkg::HEADER_MARK_RESET;
            marks_reg.tail_mark <= bsfp_pkg::TAIL_MARK_RESET;
            marks_reg.escape_mark <= bsfp_pkg::ESCAPE_MARK_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bsfp_pkg::CFG_HEADER_MARK: marks_reg.header_mark <= cfg_data;
                bsfp_pkg::CFG_TAIL_MARK:   marks_reg.tail_mark <= cfg_data;
                bsfp_pkg::CFG_ESCAPE_MARK: marks_reg.escape_mark <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    bsfp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .marks      (marks_reg),
        .queue_full (full),
        .cmd_wr_en  (cmd_wr_en),
        .cmd        (cmd)
    );

    bsfp_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cmd_wr_en),
        .wr_cmd     (cmd),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .rd_en      (head_pop)
    );

    bsfp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .marks      (marks_reg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_pop   (head_pop),
        .beat_load  (beat_load),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .last_out   (last_out)
    );

    // The queue is never written while it reports full.
    assert property (@(posedge clk) disable iff (!rst_n) cmd_wr_en |-> !full)
        else $error("command written into a full queue");

    // A command leaves the queue only on a cycle that loads a wire beat.
    assert property (@(posedge clk) disable iff (!rst_n) head_pop |-> beat_load && head_valid)
        else $error("command retired without a beat");

    // Retiring the last command of a frame puts the closing tail beat on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        head_pop && head_cmd.last |=> !empty && last_out)
        else $error("frame end did not produce the final tail beat");

    // A beat that does not retire its command never carries the last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        beat_load && !head_pop |=> !empty && !last_out)
        else $error("last flag set on a beat that does not close a frame");

endmodule

/* dv/byte_stuffing_frame_packer_top_tb.sv */
// Testbench for the byte-stuffing frame packer: queue-driven body beats, predicted wire beats.
module byte_stuffing_frame_packer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PIPE_SLACK = 16;
    localparam int RANDOM_PHASES = 6;
    localparam int BEATS_PER_PHASE = 60;
    localparam int BUSY_IDLE_PCT = 38;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hold_for_drain;
    } body_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } wire_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] data_byte = 8'd0;
    logic       last_byte = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] out_byte;
    logic       last_out;
    logic       cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_data = 8'd0;

    bsfp_pkg::marks_t mark_regs;
    logic         frame_open;
    logic [7:0]   frame_sum;
    body_beat_t   body_queue[$];
    wire_beat_t   wire_due[$];
    body_beat_t   next_body;
    wire_beat_t   due_beat;
    int           idle_pct = BUSY_IDLE_PCT;
    int           failures = 0;
    int           cycle_count = 0;

    byte_stuffing_frame_packer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last_out  (last_out),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic hits_mark(input logic [7:0] b);
        return (b == mark_regs.header_mark) || (b == mark_regs.tail_mark) ||
               (b == mark_regs.escape_mark);
    endfunction

    function automatic void expect_wire(input logic [7:0] b, input logic fin);
        wire_due.push_back(wire_beat_t'{b, fin});
    endfunction

    function automatic void expect_stuffed(input logic [7:0] b);
        if (hits_mark(b))
        begin
            expect_wire(mark_regs.escape_mark, 1'b0);
        end
        expect_wire(b, 1'b0);
    endfunction

    function automatic void pack_body_byte(input logic [7:0] b, input logic fin);
        if (!frame_open)
        begin
            expect_wire(mark_regs.header_mark, 1'b0);
            expect_wire(mark_regs.header_mark, 1'b0);
            frame_open = 1'b1;
            frame_sum = 8'd0;
        end
        expect_stuffed(b);
        frame_sum = frame_sum + b;
        if (fin)
        begin
            expect_stuffed(frame_sum);
            expect_wire(mark_regs.tail_mark, 1'b0);
            expect_wire(mark_regs.tail_mark, 1'b1);
            frame_open = 1'b0;
            frame_sum = 8'd0;
        end
    endfunction

    function automatic void queue_body(input logic [7:0] b, input logic fin, input logic hold);
        body_queue.push_back(body_beat_t'{b, fin, hold});
    endfunction

    function automatic logic [7:0] pick_body_byte();
        case ($urandom_range(0, 9))
            0: return mark_regs.header_mark;
            1: return mark_regs.tail_mark;
            2: return mark_regs.escape_mark;
            3: return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Body beat driver: a beat leaves the queue only when the slot is free, subject to random idles and drain holds.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else if (!push || !full)
        begin
            if (push)
            begin
                pack_body_byte(data_byte, last_byte);
            end
            if (body_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
                !(body_queue[0].hold_for_drain && wire_due.size() != 0))
            begin
                next_body = body_queue.pop_front();
                push <= 1'b1;
                data_byte <= next_body.data;
                last_byte <= next_body.last;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Wire beat monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (wire_due.size() == 0)
                begin
                    $error("unexpected wire beat: out_byte %02h last_out %0b",
                           out_byte, last_out);
                    failures++;
                end
                else
                begin
                    due_beat = wire_due.pop_front();
                    if (out_byte !== due_beat.out_byte)
                    begin
                        $error("out_byte expected %02h actual %02h",
                               due_beat.out_byte, out_byte);
                        failures++;
                    end
                    if (last_out !== due_beat.last_out)
                    begin
                        $error("last_out expected %0b actual %0b",
                               due_beat.last_out, last_out);
                        failures++;
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (body_queue.size() != 0 || push || wire_due.size() != 0);
        repeat (PIPE_SLACK / 4) @(negedge clk);
    endtask

    task automatic write_mark_reg(input logic [1:0] idx, input logic [7:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            bsfp_pkg::CFG_HEADER_MARK: mark_regs.header_mark = value;
            bsfp_pkg::CFG_TAIL_MARK:   mark_regs.tail_mark = value;
            bsfp_pkg::CFG_ESCAPE_MARK: mark_regs.escape_mark = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_marks(input logic [7:0] hdr, input logic [7:0] tl, input logic [7:0] esc);
        write_mark_reg(bsfp_pkg::CFG_HEADER_MARK, hdr);
        write_mark_reg(bsfp_pkg::CFG_TAIL_MARK, tl);
        write_mark_reg(bsfp_pkg::CFG_ESCAPE_MARK, esc);
        @(negedge clk);
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        mark_regs = '{bsfp_pkg::HEADER_MARK_RESET, bsfp_pkg::TAIL_MARK_RESET,
                      bsfp_pkg::ESCAPE_MARK_RESET};
        frame_open = 1'b0;
        frame_sum = 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset marks: one-beat frames, body beats equal to marks, checksum equal to
        // the escape mark, and a frame left open across the next register writes.
        queue_body(8'h00, 1'b1, 1'b0);
        queue_body(8'hFF, 1'b1, 1'b0);
        queue_body(8'hAA, 1'b0, 1'b0);
        queue_body(8'h55, 1'b0, 1'b0);
        queue_body(8'hA5, 1'b0, 1'b0);
        queue_body(8'h01, 1'b1, 1'b0);
        queue_body(8'h80, 1'b0, 1'b0);
        queue_body(8'h7F, 1'b0, 1'b0);
        wait_idle();

        set_marks(8'h00, 8'hFF, 8'h80);
        write_mark_reg(CFG_SPARE_INDEX, 8'h5A);
        @(negedge clk);
        queue_body(8'h00, 1'b0, 1'b0);
        queue_body(8'hFF, 1'b0, 1'b0);
        queue_body(8'h80, 1'b0, 1'b0);
        queue_body(8'h5A, 1'b1, 1'b0);
        wait_idle();

        // All three marks share one value.
        set_marks(8'h3C, 8'h3C, 8'h3C);
        queue_body(8'h3C, 1'b0, 1'b0);
        queue_body(8'h3C, 1'b1, 1'b0);
        queue_body(8'hC3, 1'b1, 1'b1);
        queue_body(8'h3C, 1'b1, 1'b0);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            idle_pct = (ph == 2) ? 0 : BUSY_IDLE_PCT;
            case (ph)
                1: set_marks(8'hFF, 8'h00, 8'hFF);
                3: set_marks(8'h00, 8'h00, 8'h00);
                default: set_marks(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                write_mark_reg(CFG_SPARE_INDEX, 8'($urandom_range(0, 255)));
                @(negedge clk);
            end
            for (int i = 0; i < BEATS_PER_PHASE; i++)
            begin
                queue_body(pick_body_byte(), ($urandom_range(0, 4) == 0),
                           ($urandom_range(0, 59) == 0));
            end
            wait_idle();
        end

        idle_pct = BUSY_IDLE_PCT;
        queue_body(pick_body_byte(), 1'b1, 1'b0);
        wait_idle();
        repeat (PIPE_SLACK) @(negedge clk);
        if (wire_due.size() != 0)
        begin
            $error("%0d wire beats never arrived", wire_due.size());
            failures++;
        end
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
